>>> rtl/core/ssu_pkg.sv
package ssu_pkg;

   // Result word codes
   localparam logic [2:0] EV_EXPLICIT_ACK   = 3'd0;
   localparam logic [2:0] EV_FRAGMENT_ACKED = 3'd1;
   localparam logic [2:0] EV_FRAGMENT_HDR   = 3'd2;
   localparam logic [2:0] EV_PAYLOAD_BYTE   = 3'd3;
   localparam logic [2:0] EV_MALFORMED      = 3'd4;
   localparam logic [2:0] EV_MESSAGE_DONE   = 3'd5;

   // Field widths
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned ID_W    = 32;
   localparam int unsigned INDEX_W = 11;
   localparam int unsigned SIZE_W  = 14;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned MASK_W  = 7;

   // Command queue between parser and event expander
   localparam int unsigned CMD_DEPTH = 4;
   localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // One parsed byte: an optional single event, an optional set of acked
   // fragment bits sharing one id and base index, and an optional tail event.
   typedef struct packed {
      logic               single_valid;
      logic [KIND_W-1:0]  single_kind;
      logic [MASK_W-1:0]  ack_mask;
      logic [ID_W-1:0]    message_id;
      logic [INDEX_W-1:0] fragment_index;
      logic               is_last_fragment;
      logic [SIZE_W-1:0]  fragment_size;
      logic [BYTE_W-1:0]  payload_byte;
      logic               tail_valid;
      logic [KIND_W-1:0]  tail_kind;
   } ssu_cmd_type;

   // One result word
   typedef struct packed {
      logic [KIND_W-1:0]  event_kind;
      logic [ID_W-1:0]    message_id;
      logic [INDEX_W-1:0] fragment_index;
      logic               is_last_fragment;
      logic [SIZE_W-1:0]  fragment_size;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last_of_run;
   } ssu_event_type;

endpackage

>>> rtl/core/ssu_if.sv
interface ssu_req_if import ssu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ssu_rsp_if import ssu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  event_kind;
   logic [ID_W-1:0]    message_id;
   logic [INDEX_W-1:0] fragment_index;
   logic               is_last_fragment;
   logic [SIZE_W-1:0]  fragment_size;
   logic [BYTE_W-1:0]  payload_byte;
   logic               last_of_run;

   modport source (output valid, output event_kind, output message_id,
                   output fragment_index, output is_last_fragment,
                   output fragment_size, output payload_byte,
                   output last_of_run, input ready);
   modport sink   (input valid, input event_kind, input message_id,
                   input fragment_index, input is_last_fragment,
                   input fragment_size, input payload_byte,
                   input last_of_run, output ready);
endinterface

>>> rtl/core/ssu_data_message_parser.sv
// SSU data message parser. Takes one body byte per req_chan word, with
// end_of_message on the last byte of the datagram, and returns event words on
// rsp_chan: explicit acks, acked fragments (one per set bitfield bit),
// fragment headers, payload bytes, message done and malformed; last_of_run
// marks the final word caused by one input byte, and bytes that cause no
// event give no word. A byte is accepted every cycle while the four-entry
// command queue between the parser and the event expander has room; the
// expander gives one word per cycle while the receiver is ready, so a
// bitfield byte with k set bits gives k words (up to eight with a malformed
// tail), each through the work and output registers. Truncated messages
// give a malformed word and return the parser to idle; bytes after a
// completed message are dropped up to end_of_message.
module ssu_data_message_parser import ssu_pkg::*; (
   input logic       clock,
   input logic       reset,
   ssu_req_if.sink   req_chan,
   ssu_rsp_if.source rsp_chan
);

   logic        push;
   logic        pop;
   logic        fifo_full;
   logic        fifo_valid;
   ssu_cmd_type push_cmd;
   ssu_cmd_type pop_cmd;

   ssu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   ssu_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .full      (fifo_full),
      .not_empty (fifo_valid)
   );

   ssu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_valid (fifo_valid),
      .fifo_data  (pop_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> rtl/core/ssu_front.sv
module ssu_front import ssu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   ssu_req_if.sink     req_chan,
   input  logic        fifo_full,
   output logic        push,
   output ssu_cmd_type cmd
);

   // Parse positions; unused codes behave as idle
   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_ACK_COUNT = 4'd1;
   localparam logic [3:0] PH_ACK_ID    = 4'd2;
   localparam logic [3:0] PH_BF_COUNT  = 4'd3;
   localparam logic [3:0] PH_BF_ID     = 4'd4;
   localparam logic [3:0] PH_BF_BYTE   = 4'd5;
   localparam logic [3:0] PH_FR_COUNT  = 4'd6;
   localparam logic [3:0] PH_FR_ID     = 4'd7;
   localparam logic [3:0] PH_FR_INFO   = 4'd8;
   localparam logic [3:0] PH_PAYLOAD   = 4'd9;
   localparam logic [3:0] PH_DRAIN     = 4'd10;

   logic [3:0]        phase_ff, phase_in;
   logic [1:0]        flag_ff, flag_in;
   logic [7:0]        items_ff, items_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [2:0]        bif_ff, bif_in;
   logic [7:0]        bfn_ff, bfn_in;
   logic [23:0]       hdr_ff, hdr_in;
   logic [SIZE_W-1:0] pay_ff, pay_in;

   logic              accept;
   logic [7:0]        b;
   logic              eom;
   logic              finished;
   logic [ID_W-1:0]   id_shift;
   logic [23:0]       hdr_shift;
   logic [3:0]        bif_inc;
   logic [7:0]        items_dec;
   logic [SIZE_W-1:0] pay_dec;

   assign req_chan.ready = !fifo_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.data_byte;
   assign eom            = req_chan.end_of_message;
   assign id_shift       = {id_ff[23:0], b};
   assign hdr_shift      = {hdr_ff[15:0], b};
   assign bif_inc        = {1'b0, bif_ff} + 4'd1;
   assign items_dec      = items_ff - 8'd1;
   assign pay_dec        = pay_ff - SIZE_W'(1);

   // Parse one word: next state and the command it causes
   always_comb begin
      phase_in = phase_ff;
      flag_in  = flag_ff;
      items_in = items_ff;
      id_in    = id_ff;
      bif_in   = bif_ff;
      bfn_in   = bfn_ff;
      hdr_in   = hdr_ff;
      pay_in   = pay_ff;
      finished = 1'b0;
      cmd      = '0;

      unique case (phase_ff)
         PH_ACK_COUNT: begin
            items_in = b;
            if (b == 8'd0) begin
               phase_in = flag_ff[0] ? PH_BF_COUNT : PH_FR_COUNT;
            end else begin
               phase_in = PH_ACK_ID;
               bif_in   = '0;
               id_in    = '0;
            end
         end
         PH_ACK_ID: begin
            id_in  = id_shift;
            bif_in = bif_inc[2:0];
            if (bif_inc >= 4'd4) begin
               cmd.single_valid = 1'b1;
               cmd.single_kind  = EV_EXPLICIT_ACK;
               cmd.message_id   = id_shift;
               items_in         = items_dec;
               if (items_dec == 8'd0) begin
                  phase_in = flag_ff[0] ? PH_BF_COUNT : PH_FR_COUNT;
               end else begin
                  bif_in = '0;
                  id_in  = '0;
               end
            end
         end
         PH_BF_COUNT: begin
            items_in = b;
            if (b == 8'd0) begin
               phase_in = PH_FR_COUNT;
            end else begin
               phase_in = PH_BF_ID;
               bif_in   = '0;
               id_in    = '0;
            end
         end
         PH_BF_ID: begin
            id_in  = id_shift;
            bif_in = bif_inc[2:0];
            if (bif_inc >= 4'd4) begin
               phase_in = PH_BF_BYTE;
               bfn_in   = '0;
            end
         end
         PH_BF_BYTE: begin
            // mask bit j is fragment j of this byte, taken from bit 6-j
            cmd.ack_mask       = {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
            cmd.message_id     = id_ff;
            cmd.fragment_index = {bfn_ff, 3'b000} - {3'b000, bfn_ff};
            bfn_in             = bfn_ff + 8'd1;
            if (!b[7]) begin
               items_in = items_dec;
               if (items_dec == 8'd0) begin
                  phase_in = PH_FR_COUNT;
               end else begin
                  phase_in = PH_BF_ID;
                  bif_in   = '0;
                  id_in    = '0;
               end
            end
         end
         PH_FR_COUNT: begin
            items_in = b;
            if (b == 8'd0) begin
               finished = 1'b1;
            end else begin
               phase_in = PH_FR_ID;
               bif_in   = '0;
               id_in    = '0;
            end
         end
         PH_FR_ID: begin
            id_in  = id_shift;
            bif_in = bif_inc[2:0];
            if (bif_inc >= 4'd4) begin
               phase_in = PH_FR_INFO;
               bif_in   = '0;
               hdr_in   = '0;
            end
         end
         PH_FR_INFO: begin
            hdr_in = hdr_shift;
            bif_in = bif_inc[2:0];
            if (bif_inc >= 4'd3) begin
               cmd.single_valid     = 1'b1;
               cmd.single_kind      = EV_FRAGMENT_HDR;
               cmd.message_id       = id_ff;
               cmd.fragment_index   = {4'b0000, hdr_shift[23:17]};
               cmd.is_last_fragment = hdr_shift[16];
               cmd.fragment_size    = hdr_shift[SIZE_W-1:0];
               pay_in               = hdr_shift[SIZE_W-1:0];
               if (hdr_shift[SIZE_W-1:0] == '0) begin
                  items_in = items_dec;
                  if (items_dec == 8'd0) begin
                     finished = 1'b1;
                  end else begin
                     phase_in = PH_FR_ID;
                     bif_in   = '0;
                     id_in    = '0;
                  end
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            cmd.single_valid = 1'b1;
            cmd.single_kind  = EV_PAYLOAD_BYTE;
            cmd.message_id   = id_ff;
            cmd.payload_byte = b;
            pay_in           = pay_dec;
            if (pay_dec == '0) begin
               items_in = items_dec;
               if (items_dec == 8'd0) begin
                  finished = 1'b1;
               end else begin
                  phase_in = PH_FR_ID;
                  bif_in   = '0;
                  id_in    = '0;
               end
            end
         end
         PH_DRAIN: begin
         end
         default: begin
            // flag byte: bit 7 explicit acks, bit 6 bitfields
            flag_in = b[7:6];
            if (b[7]) begin
               phase_in = PH_ACK_COUNT;
            end else begin
               phase_in = b[6] ? PH_BF_COUNT : PH_FR_COUNT;
            end
         end
      endcase

      // Completion or truncation closes the run
      if (finished) begin
         cmd.tail_valid = 1'b1;
         cmd.tail_kind  = EV_MESSAGE_DONE;
         phase_in       = eom ? PH_IDLE : PH_DRAIN;
      end else if (eom) begin
         if (phase_in != PH_DRAIN) begin
            cmd.tail_valid = 1'b1;
            cmd.tail_kind  = EV_MALFORMED;
         end
         phase_in = PH_IDLE;
      end
   end

   assign push = accept && (cmd.single_valid || (|cmd.ack_mask) || cmd.tail_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         flag_ff  <= '0;
         items_ff <= '0;
         id_ff    <= '0;
         bif_ff   <= '0;
         bfn_ff   <= '0;
         hdr_ff   <= '0;
         pay_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         flag_ff  <= flag_in;
         items_ff <= items_in;
         id_ff    <= id_in;
         bif_ff   <= bif_in;
         bfn_ff   <= bfn_in;
         hdr_ff   <= hdr_in;
         pay_ff   <= pay_in;
      end
   end

   // A word marked end of message always leaves the parser idle
   a_eom_to_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && eom) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after end of message");

endmodule

>>> rtl/core/ssu_cmd_fifo.sv
module ssu_cmd_fifo import ssu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ssu_cmd_type push_data,
   input  logic        pop,
   output ssu_cmd_type pop_data,
   output logic        full,
   output logic        not_empty
);

   ssu_cmd_type          mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command queue popped while empty");

endmodule

>>> rtl/core/ssu_back.sv
module ssu_back import ssu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fifo_valid,
   input  ssu_cmd_type fifo_data,
   output logic        pop,
   ssu_rsp_if.source   rsp_chan
);

   ssu_cmd_type   work_ff, work_in;
   logic          work_valid_ff, work_valid_in;
   ssu_event_type ev_ff, ev;
   logic          rsp_valid_ff, rsp_valid_in;

   ssu_cmd_type   work_upd;
   logic [2:0]    sel;
   logic          out_adv;
   logic          fire;
   logic          work_done;

   // Lowest pending fragment bit
   always_comb begin
      sel = '0;
      for (int j = MASK_W - 1; j >= 0; j--) begin
         if (work_ff.ack_mask[j]) begin
            sel = 3'(j);
         end
      end
   end

   // Pick the next word of the current command
   always_comb begin
      ev       = '0;
      work_upd = work_ff;
      priority if (work_ff.single_valid) begin
         ev.event_kind        = work_ff.single_kind;
         ev.message_id        = work_ff.message_id;
         ev.fragment_index    = work_ff.fragment_index;
         ev.is_last_fragment  = work_ff.is_last_fragment;
         ev.fragment_size     = work_ff.fragment_size;
         ev.payload_byte      = work_ff.payload_byte;
         work_upd.single_valid = 1'b0;
      end else if (|work_ff.ack_mask) begin
         ev.event_kind     = EV_FRAGMENT_ACKED;
         ev.message_id     = work_ff.message_id;
         ev.fragment_index = work_ff.fragment_index + {8'd0, sel};
         work_upd.ack_mask = work_ff.ack_mask & ~(MASK_W'(1) << sel);
      end else begin
         ev.event_kind       = work_ff.tail_kind;
         work_upd.tail_valid = 1'b0;
      end
      ev.last_of_run = !(work_upd.single_valid || (|work_upd.ack_mask) ||
                         work_upd.tail_valid);
   end

   assign out_adv   = !rsp_valid_ff || rsp_chan.ready;
   assign fire      = out_adv && work_valid_ff;
   assign work_done = fire && ev.last_of_run;
   assign pop       = fifo_valid && (!work_valid_ff || work_done);

   // Work register and output register
   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      if (pop) begin
         work_valid_in = 1'b1;
         work_in       = fifo_data;
      end else if (work_done) begin
         work_valid_in = 1'b0;
      end else if (fire) begin
         work_in = work_upd;
      end
      rsp_valid_in = out_adv ? fire : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (fire) begin
         ev_ff <= ev;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.event_kind       = ev_ff.event_kind;
   assign rsp_chan.message_id       = ev_ff.message_id;
   assign rsp_chan.fragment_index   = ev_ff.fragment_index;
   assign rsp_chan.is_last_fragment = ev_ff.is_last_fragment;
   assign rsp_chan.fragment_size    = ev_ff.fragment_size;
   assign rsp_chan.payload_byte     = ev_ff.payload_byte;
   assign rsp_chan.last_of_run      = ev_ff.last_of_run;

   // A held command always has a word left to give
   a_work_not_empty: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> (work_ff.single_valid || (|work_ff.ack_mask) ||
                         work_ff.tail_valid))
      else $error("empty command held in work register");

   // Done and malformed words always close their run
   a_tail_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (ev_ff.event_kind == EV_MALFORMED ||
                        ev_ff.event_kind == EV_MESSAGE_DONE)) |-> ev_ff.last_of_run)
      else $error("tail word not marked last of run");

endmodule

>>> sim/tb_ssu_data_message_parser.sv
module tb_ssu_data_message_parser;
   import ssu_pkg::*;

   localparam int RANDOM_ITEMS  = 130;
   localparam int LONG_BF_BYTES = 40;
   localparam int STALL_LIMIT   = 4000;
   localparam int MAX_REPORTS   = 40;

   // Parser position within one data message body
   typedef enum logic [3:0] {
      PH_IDLE, PH_ACK_COUNT, PH_ACK_ID, PH_BF_COUNT, PH_BF_ID, PH_BF_BYTE,
      PH_FR_COUNT, PH_FR_ID, PH_FR_INFO, PH_PAYLOAD, PH_DRAIN
   } msg_phase_type;

   logic clock;
   logic reset;

   ssu_req_if req_chan ();
   ssu_rsp_if rsp_chan ();

   ssu_data_message_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirror of the parser state
   msg_phase_type phase       = PH_IDLE;
   logic        has_acks      = 1'b0;
   logic        has_bitfields = 1'b0;
   logic [7:0]  items_left    = '0;
   logic [31:0] cur_id        = '0;
   logic [2:0]  field_bytes   = '0;
   logic [7:0]  bf_byte_num   = '0;
   logic [23:0] info_word     = '0;
   logic [13:0] payload_left  = '0;

   ssu_event_type pending_events[$];
   logic [7:0]    msg_bytes[$];

   int  fail_count      = 0;
   int  bytes_sent      = 0;
   int  drained_bytes   = 0;
   int  messages_sent   = 0;
   int  results_checked = 0;
   int  kind_count[0:7] = '{default: 0};
   int  rsp_hold_cycles = 0;
   bit  no_idle         = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Event prediction
   // ---------------------------------------------------------------
   function automatic ssu_event_type make_event(logic [2:0] kind, logic [31:0] id,
                                                logic [10:0] idx, logic last,
                                                logic [13:0] size, logic [7:0] pb);
      ssu_event_type ev;
      ev.event_kind       = kind;
      ev.message_id       = id;
      ev.fragment_index   = idx;
      ev.is_last_fragment = last;
      ev.fragment_size    = size;
      ev.payload_byte     = pb;
      ev.last_of_run      = 1'b0;
      return ev;
   endfunction

   function automatic msg_phase_type phase_after_acks();
      return has_bitfields ? PH_BF_COUNT : PH_FR_COUNT;
   endfunction

   task automatic begin_id(input msg_phase_type next);
      phase       = next;
      field_bytes = '0;
      cur_id      = '0;
   endtask

   task automatic end_fragment(output bit msg_done);
      items_left = items_left - 8'd1;
      msg_done   = (items_left == 8'd0);
      if (!msg_done) begin_id(PH_FR_ID);
   endtask

   // Walk one accepted byte and queue the words it must produce
   task automatic predict_byte(input logic [7:0] b, input logic eom);
      ssu_event_type run[0:7];
      int            n;
      bit            msg_done;
      n        = 0;
      msg_done = 1'b0;
      case (phase)
         PH_ACK_COUNT: begin
            items_left = b;
            if (b == 8'd0) phase = phase_after_acks();
            else begin_id(PH_ACK_ID);
         end
         PH_ACK_ID: begin
            cur_id      = {cur_id[23:0], b};
            field_bytes = field_bytes + 3'd1;
            if (field_bytes >= 3'd4) begin
               run[n] = make_event(EV_EXPLICIT_ACK, cur_id, '0, 1'b0, '0, '0);
               n++;
               items_left = items_left - 8'd1;
               if (items_left == 8'd0) phase = phase_after_acks();
               else begin_id(PH_ACK_ID);
            end
         end
         PH_BF_COUNT: begin
            items_left = b;
            if (b == 8'd0) phase = PH_FR_COUNT;
            else begin_id(PH_BF_ID);
         end
         PH_BF_ID: begin
            cur_id      = {cur_id[23:0], b};
            field_bytes = field_bytes + 3'd1;
            if (field_bytes >= 3'd4) begin
               phase       = PH_BF_BYTE;
               bf_byte_num = '0;
            end
         end
         PH_BF_BYTE: begin
            // bit 6 is the lowest fragment of this byte, bit 0 the highest
            for (int j = 0; j < 7; j++) begin
               if (b[6-j]) begin
                  run[n] = make_event(EV_FRAGMENT_ACKED, cur_id,
                                      11'(bf_byte_num * 7 + j), 1'b0, '0, '0);
                  n++;
               end
            end
            bf_byte_num = bf_byte_num + 8'd1;
            if (!b[7]) begin
               items_left = items_left - 8'd1;
               if (items_left == 8'd0) phase = PH_FR_COUNT;
               else begin_id(PH_BF_ID);
            end
         end
         PH_FR_COUNT: begin
            items_left = b;
            if (b == 8'd0) msg_done = 1'b1;
            else begin_id(PH_FR_ID);
         end
         PH_FR_ID: begin
            cur_id      = {cur_id[23:0], b};
            field_bytes = field_bytes + 3'd1;
            if (field_bytes >= 3'd4) begin
               phase       = PH_FR_INFO;
               field_bytes = '0;
               info_word   = '0;
            end
         end
         PH_FR_INFO: begin
            info_word   = {info_word[15:0], b};
            field_bytes = field_bytes + 3'd1;
            if (field_bytes >= 3'd3) begin
               // info bits 15 and 14 are don't-care
               run[n] = make_event(EV_FRAGMENT_HDR, cur_id, {4'd0, info_word[23:17]},
                                   info_word[16], info_word[13:0], '0);
               n++;
               payload_left = info_word[13:0];
               if (payload_left == 14'd0) end_fragment(msg_done);
               else phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            run[n] = make_event(EV_PAYLOAD_BYTE, cur_id, '0, 1'b0, '0, b);
            n++;
            payload_left = payload_left - 14'd1;
            if (payload_left == 14'd0) end_fragment(msg_done);
         end
         PH_DRAIN: begin
            drained_bytes++;
         end
         default: begin
            // flag byte
            has_acks      = b[7];
            has_bitfields = b[6];
            phase         = has_acks ? PH_ACK_COUNT : phase_after_acks();
         end
      endcase

      if (msg_done) begin
         run[n] = make_event(EV_MESSAGE_DONE, '0, '0, 1'b0, '0, '0);
         n++;
         phase = eom ? PH_IDLE : PH_DRAIN;
      end else if (eom) begin
         // truncated message
         if (phase != PH_DRAIN) begin
            run[n] = make_event(EV_MALFORMED, '0, '0, 1'b0, '0, '0);
            n++;
         end
         phase = PH_IDLE;
      end

      if (n > 0) run[n-1].last_of_run = 1'b1;
      for (int k = 0; k < n; k++) pending_events.push_back(run[k]);
   endtask

   // ---------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      ssu_event_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_checked++;
         kind_count[rsp_chan.event_kind]++;
         if (pending_events.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected word: expected none, actual kind %0d id 0x%0h",
                        $time, rsp_chan.event_kind, rsp_chan.message_id);
         end else begin
            want = pending_events.pop_front();
            check_field("event_kind", 32'(want.event_kind), 32'(rsp_chan.event_kind));
            check_field("message_id", want.message_id, rsp_chan.message_id);
            check_field("fragment_index", 32'(want.fragment_index),
                        32'(rsp_chan.fragment_index));
            check_field("is_last_fragment", 32'(want.is_last_fragment),
                        32'(rsp_chan.is_last_fragment));
            check_field("fragment_size", 32'(want.fragment_size),
                        32'(rsp_chan.fragment_size));
            check_field("payload_byte", 32'(want.payload_byte),
                        32'(rsp_chan.payload_byte));
            check_field("last_of_run", 32'(want.last_of_run),
                        32'(rsp_chan.last_of_run));
         end
      end
   end

   // Receiver: random stalls, plus long hold-offs on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_chan.ready = no_idle || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // Watchdog on cycles with no word moving on either side
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic eom);
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(0, 99) < 29) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid          = 1'b1;
      req_chan.data_byte      = b;
      req_chan.end_of_message = eom;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_byte(b, eom);
      bytes_sent++;
   endtask

   // Send the staged bytes, end_of_message on the last one
   task automatic send_msg_bytes();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      messages_sent++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_id(input logic [31:0] id);
      msg_bytes.push_back(id[31:24]);
      msg_bytes.push_back(id[23:16]);
      msg_bytes.push_back(id[15:8]);
      msg_bytes.push_back(id[7:0]);
   endtask

   // Well-formed message with random content; dense forces full bitfields
   task automatic build_message(input bit dense);
      logic [7:0]  flag;
      logic [7:0]  bf;
      logic [23:0] info;
      int          n_acks, n_bf, n_fr, n_bytes, size;
      msg_bytes.delete();
      flag = 8'($urandom);
      if (dense) flag[6] = 1'b1;
      msg_bytes.push_back(flag);
      if (flag[7]) begin
         n_acks = $urandom_range(0, 3);
         msg_bytes.push_back(8'(n_acks));
         repeat (n_acks) push_id(pick_id());
      end
      if (flag[6]) begin
         n_bf = dense ? $urandom_range(1, 3) : $urandom_range(0, 3);
         msg_bytes.push_back(8'(n_bf));
         repeat (n_bf) begin
            push_id(pick_id());
            n_bytes = $urandom_range(1, 3);
            for (int k = 0; k < n_bytes; k++) begin
               bf = 8'($urandom);
               if (dense) bf[6:0] = 7'h7F;
               bf[7] = (k < n_bytes - 1);
               msg_bytes.push_back(bf);
            end
         end
      end
      n_fr = $urandom_range(0, 3);
      msg_bytes.push_back(8'(n_fr));
      repeat (n_fr) begin
         push_id(pick_id());
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
         info = {7'($urandom), 1'($urandom), 2'($urandom), 14'(size)};
         msg_bytes.push_back(info[23:16]);
         msg_bytes.push_back(info[15:8]);
         msg_bytes.push_back(info[7:0]);
         repeat (size) msg_bytes.push_back(8'($urandom));
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed();
      // empty body: no sections, zero fragments
      msg_bytes = '{8'h00, 8'h00};
      send_msg_bytes();
      // all flag bits, one explicit ack, empty bitfield list, one zero-size
      // last fragment with unused info bits set, then a trailing byte
      msg_bytes = '{8'hFF, 8'h01, 8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00, 8'h01,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hC0, 8'h00, 8'h5A};
      send_msg_bytes();
      // max fragment size, cut short inside the payload
      msg_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h3F, 8'hFF, 8'hA5};
      send_msg_bytes();
      // two full bitfield bytes, cut on the second: eight words from one byte
      msg_bytes = '{8'h40, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'h7F};
      send_msg_bytes();
   endtask

   task automatic test_count_extremes();
      msg_bytes = '{8'h80, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
      send_msg_bytes();
      msg_bytes = '{8'h40, 8'hFF, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00};
      send_msg_bytes();
      msg_bytes = '{8'h00, 8'hFF, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
                    8'h01, 8'h00, 8'h00, 8'h77};
      send_msg_bytes();
   endtask

   // One entry spread over many bitfield bytes
   task automatic test_long_bitfield();
      logic [7:0] bf;
      msg_bytes = '{8'h40, 8'h01};
      push_id(pick_id());
      for (int k = 0; k < LONG_BF_BYTES; k++) begin
         bf = 8'h00;
         if (k == 0 || k >= LONG_BF_BYTES - 8 || $urandom_range(0, 3) == 0)
            bf[6:0] = 7'($urandom);
         if (k == LONG_BF_BYTES - 2) bf[6:0] = 7'h7F;
         bf[7] = (k < LONG_BF_BYTES - 1);
         msg_bytes.push_back(bf);
      end
      msg_bytes.push_back(8'h00);
      send_msg_bytes();
   endtask

   // Receiver holds off while the sender keeps offering event-heavy bytes
   task automatic test_backpressure();
      rsp_hold_cycles = 300;
      repeat (2) begin
         build_message(1'b1);
         send_msg_bytes();
      end
      wait_for_results();
   endtask

   // Sender goes quiet until every word has come back
   task automatic test_sender_pause();
      repeat (2) begin
         build_message(1'b0);
         send_msg_bytes();
         wait_for_results();
      end
   endtask

   task automatic test_random();
      int start_items, done_items, mode, cut;
      start_items = bytes_sent - drained_bytes;
      done_items  = 0;
      while (done_items < RANDOM_ITEMS) begin
         no_idle = (done_items >= 40 && done_items < 100);
         mode    = $urandom_range(0, 99);
         if (mode < 8) begin
            // noise, with end marks falling anywhere
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            send_byte(8'($urandom), 1'b1);
         end else begin
            build_message(1'b0);
            if (mode < 22) begin
               cut = $urandom_range(0, msg_bytes.size() - 1);
               while (msg_bytes.size() > cut + 1) void'(msg_bytes.pop_back());
            end else if (mode < 32) begin
               repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
            end
            send_msg_bytes();
         end
         if ($urandom_range(0, 9) == 0) wait_for_results();
         done_items = bytes_sent - drained_bytes - start_items;
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.data_byte      = '0;
      req_chan.end_of_message = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_count_extremes();
      test_long_bitfield();
      test_backpressure();
      test_sender_pause();
      test_random();

      wait_for_results();
      repeat (12) @(posedge clock);
      if (pending_events.size() != 0) begin
         fail_count++;
         $display("%0t: %0d words still expected, none arrived", $time,
                  pending_events.size());
      end

      $display("Ran %0d messages, %0d body bytes (%0d dropped after completion), %0d words",
               messages_sent, bytes_sent, drained_bytes, results_checked);
      $display("Words: %0d acks, %0d acked frags, %0d headers, %0d payload, %0d bad, %0d done",
               kind_count[EV_EXPLICIT_ACK], kind_count[EV_FRAGMENT_ACKED],
               kind_count[EV_FRAGMENT_HDR], kind_count[EV_PAYLOAD_BYTE],
               kind_count[EV_MALFORMED], kind_count[EV_MESSAGE_DONE]);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
